// ===== src/quat_to_euler_angle_smoother_defines.svh =====
// Assertion macros shared by the quaternion to Euler angle smoother RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef QUAT_TO_EULER_ANGLE_SMOOTHER_DEFINES_SVH
`define QUAT_TO_EULER_ANGLE_SMOOTHER_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define QTE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/qte_pkg.sv =====
// Shared types and constants of the quaternion to Euler angle smoother.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;
  localparam int QW        = 15;
  localparam int AW        = 16;
  localparam int VW        = 44;
  localparam int ZW        = 26;
  localparam int MAX_STEPS = 24;
  localparam int SQW       = 62;
  localparam int SQ_STEPS  = 31;

  typedef logic signed [AW-1:0] angle_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // Arctangent of 2^-i in degrees * 65536, rounded.
  localparam logic signed [ZW-1:0] ATAN_TAB [MAX_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
    26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
  };

  localparam logic signed [ZW-1:0] Z_QUARTER   = 26'sd5898240;
  localparam logic signed [VW-1:0] LIM_COARSE  = 44'sh000_0001_0000_0000 >>> 0;
  localparam logic signed [VW-1:0] LIM_NORM    = 44'sh100_0000_0000;

  localparam angle_t HALF_TURN    = 16'sd23040;
  localparam angle_t QUARTER_TURN = 16'sd11520;

  // Register addresses (word index).
  localparam logic [1:0] REG_DEADZONE = 2'd0;
  localparam logic [1:0] REG_GAIN     = 2'd1;
  localparam logic [1:0] REG_INVERT   = 2'd2;
endpackage
`default_nettype wire

// ===== src/quat_to_euler_angle_smoother.sv =====
// Top level: quaternion to roll/pitch/yaw with wrapped smoothing.
// Depends on qte_pkg, qte_isqrt, qte_cordic_cell, qte_smooth and the defines header.
//
//  Channel | Direction | Words           | Payload
//  in_     | slave     | quaternion      | tdata: i, j, k, real; tuser: restart
//  out_    | master    | angle triple    | tdata: roll, pitch, yaw
//  cfg_    | APB slave | register access | deadzone, smooth_gain, invert_mask
//
// One word is processed at a time. The span is set by the square root, which is skipped
// when the asin argument reaches one, the vector normalization, the feed of the three
// lanes and the drain of the cell chain.
// Reset is synchronous, active low; after reset the first word passes through raw.
// A finished word waits in the output register; the next word is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module quat_to_euler_angle_smoother #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_i[14:0], quat_j[29:15], quat_k[44:30],
                                  // quat_real[59:45], zero fill
  input  logic        in_tuser,   // restart[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle[15:0], pitch_angle[31:16],
                                  // yaw_angle[47:32]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import qte_pkg::*;
`include "quat_to_euler_angle_smoother_defines.svh"

  localparam int LANES = 3;
  localparam logic [1:0] LANE_ROLL  = 2'd0;
  localparam logic [1:0] LANE_YAW   = 2'd1;
  localparam logic [1:0] LANE_PITCH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_SUM, S_SQ, S_CMP, S_ROOT, S_LOAD,
    S_NORM, S_FEED, S_DRAIN, S_POST, S_SMOOTH, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [11:0] deadzone_r;
  logic [16:0] gain_r;
  logic [2:0]  invert_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_DEADZONE: cfg_prdata = {20'b0, deadzone_r};
      REG_GAIN:     cfg_prdata = {15'b0, gain_r};
      REG_INVERT:   cfg_prdata = {29'b0, invert_r};
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= 12'd26;
      gain_r     <= 17'd19661;
      invert_r   <= 3'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_DEADZONE: deadzone_r <= cfg_pwdata[11:0];
        REG_GAIN:     gain_r     <= cfg_pwdata[16:0];
        REG_INVERT:   invert_r   <= cfg_pwdata[2:0];
        default:      ;
      endcase
    end
  end

  // Datapath registers.
  logic signed [QW-1:0] qi_r, qj_r, qk_r, qw_r;
  logic                 restart_r;
  logic                 first_r;
  logic signed [29:0]   p_ww_r, p_ii_r, p_jj_r, p_kk_r;
  logic signed [29:0]   p_wi_r, p_jk_r, p_wk_r, p_ij_r, p_wj_r, p_ki_r;
  logic [30:0]          m_r;
  logic signed [31:0]   s_r, ry_r, rx_r, yy_r, yx_r;
  logic [SQW-1:0]       mm_r, ss_r;
  logic                 mzero_r;
  logic                 czero_r;
  logic [SQ_STEPS-1:0]  c_r;
  vec_t                 lane_r  [LANES];
  logic                 zero_r  [LANES];
  logic signed [ZW-1:0] zout_r  [LANES];
  logic [1:0]           feed_cnt_r;
  logic [1:0]           col_cnt_r;
  angle_t               raw_r   [LANES];
  angle_t               prev_r  [LANES];
  logic                 out_tvalid_r;
  logic [47:0]          out_tdata_r;

  // Square root unit.
  logic                sq_start;
  logic                sq_done;
  logic [SQ_STEPS-1:0] sq_root;
  logic [31:0]         s_abs;

  assign s_abs    = (s_r < 0) ? -s_r : s_r;
  assign sq_start = (state_r == S_CMP) && !(ss_r >= mm_r);

  qte_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (mm_r - ss_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // CORDIC cell chain.
  logic chain_valid [CORDIC_STEPS+1];
  vec_t chain_vec   [CORDIC_STEPS+1];

  assign chain_valid[0] = (state_r == S_FEED);
  assign chain_vec[0]   = lane_r[feed_cnt_r];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    qte_cordic_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[g]),
      .in_vec    (chain_vec[g]),
      .out_valid (chain_valid[g+1]),
      .out_vec   (chain_vec[g+1])
    );
  end

  // Left half plane vectors are turned a quarter turn into the right half.
  function automatic vec_t prerot(input logic signed [VW-1:0] xi,
                                  input logic signed [VW-1:0] yi);
    vec_t v;
    v.x = xi;
    v.y = yi;
    v.z = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        v.x = yi;
        v.y = -xi;
        v.z = Z_QUARTER;
      end else begin
        v.x = -yi;
        v.y = xi;
        v.z = -Z_QUARTER;
      end
    end
    return v;
  endfunction

  function automatic logic below(input logic signed [VW-1:0] v,
                                 input logic signed [VW-1:0] lim);
    return (v < lim) && (v > -lim);
  endfunction

  // Round the accumulated angle to degrees * 128 and wrap once.
  function automatic angle_t to_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] zr;
    logic signed [17:0]   a;
    zr = z + 26'sd256;
    a  = 18'(zr >>> 9);
    if (a > 18'sd23040) begin
      a = a - 18'sd46080;
    end else if (a < -18'sd23040) begin
      a = a + 18'sd46080;
    end
    return a[AW-1:0];
  endfunction

  // Normalization per lane.
  logic norm_done [LANES];
  logic norm_fine [LANES];
  logic all_done;

  always_comb begin
    all_done = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      norm_done[l] = zero_r[l] || !below(lane_r[l].x, LIM_NORM) ||
                     !below(lane_r[l].y, LIM_NORM);
      norm_fine[l] = !(below(lane_r[l].x, LIM_COARSE) && below(lane_r[l].y, LIM_COARSE));
      all_done     = all_done && norm_done[l];
    end
  end

  // Raw angles from the chain results.
  angle_t ang_roll, ang_yaw, ang_pitch, pitch_c;
  angle_t raw_nxt [LANES];

  always_comb begin
    ang_roll  = zero_r[LANE_ROLL]  ? '0 : to_angle(zout_r[LANE_ROLL]);
    ang_yaw   = zero_r[LANE_YAW]   ? '0 : to_angle(zout_r[LANE_YAW]);
    ang_pitch = zero_r[LANE_PITCH] ? '0 : to_angle(zout_r[LANE_PITCH]);
    if (czero_r) begin
      pitch_c = (s_r > 0) ? QUARTER_TURN : -QUARTER_TURN;
    end else if (ang_pitch > QUARTER_TURN) begin
      pitch_c = QUARTER_TURN;
    end else if (ang_pitch < -QUARTER_TURN) begin
      pitch_c = -QUARTER_TURN;
    end else begin
      pitch_c = ang_pitch;
    end
    if (mzero_r) begin
      ang_roll = '0;
      ang_yaw  = '0;
      pitch_c  = '0;
    end
    raw_nxt[LANE_ROLL]  = invert_r[0] ? -ang_roll : ang_roll;
    raw_nxt[LANE_PITCH] = invert_r[1] ? -pitch_c  : pitch_c;
    raw_nxt[LANE_YAW]   = invert_r[2] ? -ang_yaw  : ang_yaw;
  end

  // Smoothing filters, one per axis.
  logic   sm_done [LANES];
  angle_t sm_res  [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_smooth
    qte_smooth u_smooth (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (state_r == S_POST),
      .prev     (prev_r[g]),
      .raw      (raw_nxt[g]),
      .deadzone (deadzone_r),
      .gain     (gain_r),
      .done     (sm_done[g]),
      .result   (sm_res[g])
    );
  end

  angle_t fin [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fin[l] = (first_r || restart_r) ? raw_r[l] : sm_res[l];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_r      <= 1'b1;
      out_tvalid_r <= 1'b0;
      feed_cnt_r   <= '0;
      col_cnt_r    <= '0;
      for (int l = 0; l < LANES; l++) begin
        prev_r[l] <= '0;
      end
    end else begin
      // The output state decides the valid flag on its own.
      if (out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            qi_r      <= in_tdata[14:0];
            qj_r      <= in_tdata[29:15];
            qk_r      <= in_tdata[44:30];
            qw_r      <= in_tdata[59:45];
            restart_r <= in_tuser;
            state_r   <= S_PROD;
          end
        end
        S_PROD: begin
          p_ww_r  <= qw_r * qw_r;
          p_ii_r  <= qi_r * qi_r;
          p_jj_r  <= qj_r * qj_r;
          p_kk_r  <= qk_r * qk_r;
          p_wi_r  <= qw_r * qi_r;
          p_jk_r  <= qj_r * qk_r;
          p_wk_r  <= qw_r * qk_r;
          p_ij_r  <= qi_r * qj_r;
          p_wj_r  <= qw_r * qj_r;
          p_ki_r  <= qk_r * qi_r;
          state_r <= S_SUM;
        end
        S_SUM: begin
          m_r  <= 31'(p_ww_r) + 31'(p_ii_r) + 31'(p_jj_r) + 31'(p_kk_r);
          s_r  <= (32'(p_wj_r) - 32'(p_ki_r)) <<< 1;
          ry_r <= (32'(p_wi_r) + 32'(p_jk_r)) <<< 1;
          rx_r <= 32'(p_ww_r) + 32'(p_kk_r) - 32'(p_ii_r) - 32'(p_jj_r);
          yy_r <= (32'(p_wk_r) + 32'(p_ij_r)) <<< 1;
          yx_r <= 32'(p_ww_r) + 32'(p_ii_r) - 32'(p_jj_r) - 32'(p_kk_r);
          state_r <= S_SQ;
        end
        S_SQ: begin
          mm_r    <= m_r * m_r;
          ss_r    <= s_abs[30:0] * s_abs[30:0];
          mzero_r <= (m_r == '0);
          state_r <= S_CMP;
        end
        S_CMP: begin
          czero_r <= (ss_r >= mm_r);
          if (ss_r >= mm_r) begin
            c_r     <= '0;
            state_r <= S_LOAD;
          end else begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            c_r     <= sq_root;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          lane_r[LANE_ROLL]  <= prerot(VW'(rx_r), VW'(ry_r));
          lane_r[LANE_YAW]   <= prerot(VW'(yx_r), VW'(yy_r));
          lane_r[LANE_PITCH] <= prerot({{(VW-SQ_STEPS){1'b0}}, c_r}, VW'(s_r));
          zero_r[LANE_ROLL]  <= (rx_r == '0) && (ry_r == '0);
          zero_r[LANE_YAW]   <= (yx_r == '0) && (yy_r == '0);
          zero_r[LANE_PITCH] <= (c_r == '0) && (s_r == '0);
          state_r <= S_NORM;
        end
        S_NORM: begin
          for (int l = 0; l < LANES; l++) begin
            if (!norm_done[l]) begin
              if (norm_fine[l]) begin
                lane_r[l].x <= lane_r[l].x <<< 1;
                lane_r[l].y <= lane_r[l].y <<< 1;
              end else begin
                lane_r[l].x <= lane_r[l].x <<< 8;
                lane_r[l].y <= lane_r[l].y <<< 8;
              end
            end
          end
          if (all_done) begin
            feed_cnt_r <= '0;
            state_r    <= S_FEED;
          end
        end
        S_FEED: begin
          feed_cnt_r <= feed_cnt_r + 2'd1;
          if (feed_cnt_r == 2'(LANES - 1)) begin
            col_cnt_r <= '0;
            state_r   <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (chain_valid[CORDIC_STEPS]) begin
            zout_r[col_cnt_r] <= chain_vec[CORDIC_STEPS].z;
            col_cnt_r         <= col_cnt_r + 2'd1;
            if (col_cnt_r == 2'(LANES - 1)) begin
              state_r <= S_POST;
            end
          end
        end
        S_POST: begin
          for (int l = 0; l < LANES; l++) begin
            raw_r[l] <= raw_nxt[l];
          end
          state_r <= S_SMOOTH;
        end
        S_SMOOTH: begin
          if (sm_done[0]) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            for (int l = 0; l < LANES; l++) begin
              prev_r[l] <= fin[l];
            end
            out_tdata_r  <= {fin[LANE_YAW], fin[LANE_PITCH], fin[LANE_ROLL]};
            out_tvalid_r <= 1'b1;
            first_r      <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Roll field of the output word stays within a half turn.
  logic signed [AW-1:0] roll_out;
  logic                 roll_ok;

  assign roll_out = out_tdata[15:0];
  assign roll_ok  = (roll_out <= HALF_TURN) && (roll_out >= -HALF_TURN);

  // Checks on the sequencing and on the roll range.
  `QTE_ASSERT_NEXT(a_one_word, in_tvalid && in_tready, !in_tready, "word taken while busy")
  `QTE_ASSERT_IMPL(a_chain_drain, chain_valid[CORDIC_STEPS], state_r == S_DRAIN, "stray output")
  `QTE_ASSERT_IMPL(a_out_range, out_tvalid, roll_ok, "roll out of range")
endmodule
`default_nettype wire

// ===== src/qte_cordic_cell.sv =====
// One CORDIC vectoring cell: a fixed shift and angle, registered output.
// Depends on qte_pkg for the vector type and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  qte_pkg::vec_t in_vec,
  output logic          out_valid,
  output qte_pkg::vec_t out_vec
);
  import qte_pkg::*;

  vec_t vec_nxt;
  vec_t vec_r;
  logic valid_r;

  // Rotate toward the x axis; direction follows the sign of y.
  always_comb begin
    if (in_vec.y > 0) begin
      vec_nxt.x = in_vec.x + (in_vec.y >>> IDX);
      vec_nxt.y = in_vec.y - (in_vec.x >>> IDX);
      vec_nxt.z = in_vec.z + ATAN_TAB[IDX];
    end else begin
      vec_nxt.x = in_vec.x - (in_vec.y >>> IDX);
      vec_nxt.y = in_vec.y + (in_vec.x >>> IDX);
      vec_nxt.z = in_vec.z - ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    vec_r <= vec_nxt;
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;
endmodule
`default_nettype wire

// ===== src/qte_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on qte_pkg for the radicand width and step count.
`timescale 1ns / 1ps
`default_nettype none
module qte_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [qte_pkg::SQW-1:0] radicand,
  output logic                   done,
  output logic [qte_pkg::SQ_STEPS-1:0] root
);
  import qte_pkg::*;

  logic [SQW-1:0] v_r;
  logic [SQW-1:0] r_r;
  logic [4:0]     cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [SQW-1:0] bit_w;
  logic [SQW-1:0] trial;

  assign bit_w = SQW'(1) << {cnt_r, 1'b0};
  assign trial = r_r + bit_w;

  // Classic digit-by-digit root, starting from the top bit pair.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        v_r    <= radicand;
        r_r    <= '0;
        cnt_r  <= 5'(SQ_STEPS - 1);
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_w;
        end else begin
          r_r <= r_r >> 1;
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[SQ_STEPS-1:0];
endmodule
`default_nettype wire

// ===== src/qte_smooth.sv =====
// Two-stage smoothing filter for one angle: wrapped difference, deadzone,
// gain multiply, then rounded add and wrap. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_smooth (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  qte_pkg::angle_t prev,
  input  qte_pkg::angle_t raw,
  input  logic [11:0]     deadzone,
  input  logic [16:0]     gain,
  output logic            done,
  output qte_pkg::angle_t result
);
  import qte_pkg::*;

  logic signed [17:0] d0;
  logic signed [17:0] d1;
  logic signed [17:0] ad;
  logic               hold_r;
  logic signed [35:0] prod_r;
  angle_t             prev_r;
  logic               v1_r;
  logic signed [35:0] qr;
  logic signed [19:0] sum;
  logic signed [19:0] w1;
  logic signed [19:0] w2;
  angle_t             result_r;
  logic               done_r;

  // Stage one: shortest wrapped difference and the hold decision.
  always_comb begin
    d0 = 18'(raw) - 18'(prev);
    if (d0 > 18'sd23040) begin
      d1 = d0 - 18'sd46080;
    end else if (d0 < -18'sd23040) begin
      d1 = d0 + 18'sd46080;
    end else begin
      d1 = d0;
    end
    ad = (d1 < 0) ? -d1 : d1;
  end

  // Stage two: round the product, add, wrap back into a half turn.
  always_comb begin
    qr  = (prod_r + 36'sd32768) >>> 16;
    sum = 20'(prev_r) + qr[19:0];
    if (sum > 20'sd23040) begin
      w1 = sum - 20'sd46080;
    end else if (sum < -20'sd23040) begin
      w1 = sum + 20'sd46080;
    end else begin
      w1 = sum;
    end
    if (w1 > 20'sd23040) begin
      w2 = w1 - 20'sd46080;
    end else if (w1 < -20'sd23040) begin
      w2 = w1 + 20'sd46080;
    end else begin
      w2 = w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
    hold_r   <= ad < $signed({6'b0, deadzone});
    prod_r   <= d1 * $signed({1'b0, gain});
    prev_r   <= prev;
    result_r <= hold_r ? prev_r : w2[AW-1:0];
  end

  assign done   = done_r;
  assign result = result_r;
endmodule
`default_nettype wire

// ===== test/tb_quat_to_euler_angle_smoother.sv =====
// Self-checking testbench for the quaternion to roll/pitch/yaw smoother.
// Depends on qte_pkg and quat_to_euler_angle_smoother; predicts every angle triple itself.
`timescale 1ns / 1ps
module tb_quat_to_euler_angle_smoother;
  import qte_pkg::*;

  localparam int NUM_RANDOM   = 1330;
  localparam int WATCHDOG_MAX = 20000;
  localparam int STEPS        = 16;

  // One directed word; chk marks rows whose expected triple is typed in.
  typedef struct {
    logic signed [14:0] qi, qj, qk, qw;
    logic               rst;
    bit                 chk;
    logic signed [15:0] er, ep, ey;
  } vec_row_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [63:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [47:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  quat_to_euler_angle_smoother #(.CORDIC_STEPS(STEPS)) uut (.*);

  // Predictor state and register copies.
  int unsigned dz_reg, gain_reg, inv_reg;
  int          hold_roll, hold_pitch, hold_yaw;
  bit          first_word;
  logic [47:0] angle_q[$];
  int          mismatches, idle_cycles;
  bit          hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return (v >= 0) ? (v >>> s) : -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic int wrap_angle(longint a);
    while (a > 23040) a -= 46080;
    while (a < -23040) a += 46080;
    return int'(a);
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan_entry(int i);
    longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115,
                      57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  // Vectoring CORDIC angle of (x, y) in degrees * 128.
  function automatic int vector_angle(longint y, longint x);
    longint z, t, ax, ay, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    while (ax < (64'sd1 <<< 40) && ay < (64'sd1 <<< 40)) begin
      x *= 2; y *= 2; ax *= 2; ay *= 2;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_entry(i);
      end else begin
        nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_entry(i);
      end
      x = nx; y = ny;
    end
    return wrap_angle(floor_shr(z + 256, 9));
  endfunction

  function automatic int smooth_axis(int prev, int raw);
    longint d, ad;
    d = wrap_angle(longint'(raw) - prev);
    ad = d < 0 ? -d : d;
    if (ad < dz_reg) return prev;
    return wrap_angle(prev + floor_shr(d * longint'(gain_reg) + 32768, 16));
  endfunction

  // Computes the next filtered triple and updates the held angles.
  function automatic logic [47:0] predict_angles(logic [63:0] d, logic rst);
    longint qi, qj, qk, qw, m, s, c;
    longint unsigned mm, ss;
    int r, p, y;
    qi = longint'($signed(d[14:0]));
    qj = longint'($signed(d[29:15]));
    qk = longint'($signed(d[44:30]));
    qw = longint'($signed(d[59:45]));
    r = 0; p = 0; y = 0;
    m = qw*qw + qi*qi + qj*qj + qk*qk;
    if (m != 0) begin
      s = 2 * (qw*qj - qk*qi);
      mm = longint'(m) * longint'(m);
      ss = s < 0 ? -s : s;
      ss = ss * ss;
      c = (ss >= mm) ? 0 : int_root(mm - ss);
      r = vector_angle(2 * (qw*qi + qj*qk), qw*qw + qk*qk - qi*qi - qj*qj);
      y = vector_angle(2 * (qw*qk + qi*qj), qw*qw + qi*qi - qj*qj - qk*qk);
      if (c == 0) p = s > 0 ? 11520 : -11520;
      else p = vector_angle(s, c);
      if (p > 11520) p = 11520;
      if (p < -11520) p = -11520;
    end
    if (inv_reg[0]) r = -r;
    if (inv_reg[1]) p = -p;
    if (inv_reg[2]) y = -y;
    if (first_word || rst) begin
      hold_roll = r; hold_pitch = p; hold_yaw = y;
    end else begin
      hold_roll = smooth_axis(hold_roll, r);
      hold_pitch = smooth_axis(hold_pitch, p);
      hold_yaw = smooth_axis(hold_yaw, y);
    end
    first_word = 0;
    return {hold_yaw[15:0], hold_pitch[15:0], hold_roll[15:0]};
  endfunction

  // Two-phase register write that also updates the predictor's copy of the register.
  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      REG_DEADZONE: dz_reg = val & 32'hFFF;
      REG_GAIN:     gain_reg = val & 32'h1FFFF;
      default:      inv_reg = val & 32'h7;
    endcase
  endtask

  task automatic send_word(logic [63:0] d, logic rst);
    in_tvalid <= 1; in_tdata <= d; in_tuser <= rst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    angle_q.push_back(predict_angles(d, rst));
  endtask

  task automatic sender_gap();
    int g;
    if ($urandom_range(0, 2) == 0) begin
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Waits until all results are in, plus a margin so the block is idle.
  task automatic drain();
    in_tvalid <= 0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [63:0] pack_quat(int qi, int qj, int qk, int qw);
    return {4'd0, qw[14:0], qk[14:0], qj[14:0], qi[14:0]};
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected angle word %h", out_tdata);
      end else begin
        logic [47:0] e;
        e = angle_q.pop_front();
        if (e !== out_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Angle mismatch: expected r=%0d p=%0d y=%0d got r=%0d p=%0d y=%0d",
                     $signed(e[15:0]), $signed(e[31:16]), $signed(e[47:32]),
                     $signed(out_tdata[15:0]), $signed(out_tdata[31:16]),
                     $signed(out_tdata[47:32]));
        end
      end
    end
  end

  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 0;
      else if ($urandom_range(0, 3) == 0) out_tready <= 0;
      else out_tready <= 1;
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    vec_row_t rows[$];
    logic signed [14:0] a, b, cc, w;
    int mode;
    logic [63:0] d;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    mismatches = 0; idle_cycles = 0; hold_off = 0;
    dz_reg = 26; gain_reg = 19661; inv_reg = 0;
    hold_roll = 0; hold_pitch = 0; hold_yaw = 0; first_word = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed table: zero quaternion, identity, extremes, gimbal lock.
    rows.push_back('{0, 0, 0, 0, 0, 1, 0, 0, 0});
    rows.push_back('{0, 0, 0, 16383, 1, 1, 0, 0, 0});
    rows.push_back('{16383, 0, 0, 0, 1, 1, 23040, 0, 0});
    rows.push_back('{0, 0, 16383, 0, 1, 1, 0, 0, 23040});
    rows.push_back('{0, 11585, 0, 11585, 1, 1, 0, 11520, 0});
    rows.push_back('{0, -11585, 0, 11585, 1, 1, 0, -11520, 0});
    rows.push_back('{-16384, -16384, -16384, -16384, 0, 0, 0, 0, 0});
    rows.push_back('{16383, 16383, 16383, 16383, 0, 0, 0, 0, 0});
    rows.push_back('{-16384, 0, 0, 0, 0, 0, 0, 0, 0});
    rows.push_back('{0, -16384, 0, 0, 0, 0, 0, 0, 0});
    rows.push_back('{0, 0, -16384, 0, 0, 0, 0, 0, 0});
    rows.push_back('{0, 0, 0, -16384, 0, 0, 0, 0, 0});
    rows.push_back('{1, 0, 0, 0, 0, 0, 0, 0, 0});
    rows.push_back('{3000, -2000, 9000, 12000, 0, 0, 0, 0, 0});
    rows.push_back('{3010, -2005, 9002, 12000, 0, 0, 0, 0, 0});
    rows.push_back('{-5000, 4000, -9000, -8000, 1, 0, 0, 0, 0});
    foreach (rows[n]) begin
      logic [47:0] e;
      d = pack_quat(rows[n].qi, rows[n].qj, rows[n].qk, rows[n].qw);
      send_word(d, rows[n].rst);
      e = angle_q[$];
      if (rows[n].chk && e !== {rows[n].ey, rows[n].ep, rows[n].er}) begin
        mismatches++;
        if (mismatches <= 10) $display("Directed row %0d predicts %h", n, e);
      end
    end
    drain();

    // Random phases over several register settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_DEADZONE, 0); write_reg(REG_GAIN, 65536);
                 write_reg(REG_INVERT, 7); end
        1: begin write_reg(REG_DEADZONE, 2560); write_reg(REG_GAIN, 0);
                 write_reg(REG_INVERT, 0); end
        2: begin write_reg(REG_DEADZONE, 4095); write_reg(REG_GAIN, 131071);
                 write_reg(REG_INVERT, 5); end
        default: begin
          write_reg(REG_DEADZONE, $urandom_range(0, 400));
          write_reg(REG_GAIN, $urandom_range(0, 80000));
          write_reg(REG_INVERT, $urandom_range(0, 7));
        end
      endcase
      for (int n = 0; n < NUM_RANDOM / 6; n++) begin
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
          // Orientation near identity, keeps the filter in its normal regime.
          a  = 15'($urandom_range(0, 4000) - 2000);
          b  = 15'($urandom_range(0, 4000) - 2000);
          cc = 15'($urandom_range(0, 4000) - 2000);
          w  = 15'(14000 + $urandom_range(0, 2383));
        end else if (mode < 7) begin
          a = 15'($urandom); b = 15'($urandom); cc = 15'($urandom); w = 15'($urandom);
        end else if (mode == 7) begin
          // Near gimbal lock.
          a  = 15'($urandom_range(0, 20) - 10);
          cc = 15'($urandom_range(0, 20) - 10);
          b  = 15'(11585 + $urandom_range(0, 6));
          w  = $urandom_range(0, 1) ? 15'sd11585 : -15'sd11585;
        end else begin
          a  = $urandom_range(0, 1) ? 15'h4000 : 15'h3FFF;
          b  = 15'($urandom_range(0, 3) - 1);
          cc = 15'($urandom);
          w  = $urandom_range(0, 1) ? 15'h0000 : 15'h4000;
        end
        send_word(pack_quat(a, b, cc, w), $urandom_range(0, 15) == 0);
        if (ph == 3 && n == 20) begin
          // Long receiver stall while the sender keeps offering words.
          hold_off = 1;
          fork
            begin repeat (600) @(posedge clk); hold_off = 0; end
          join_none
        end
        if (ph == 4 && n == 30) begin
          in_tvalid <= 0;
          while (angle_q.size() != 0) @(posedge clk);
        end
        sender_gap();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/qte_pkg.sv
src/qte_cordic_cell.sv
src/qte_isqrt.sv
src/qte_smooth.sv
src/quat_to_euler_angle_smoother.sv
test/tb_quat_to_euler_angle_smoother.sv
